[hdl/bfph_pkg.sv]
// Shared types and constants for the byte ring FIFO with peak hold.
// No dependencies; bfph_ctrl, the top level and the testbench use it by scoped names.
package bfph_pkg;

  localparam int DEPTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = 6;
  localparam int DATA_W = 8;
  localparam int CMD_W  = 2;

  localparam logic [LEN_W-1:0] DEPTH_LEN  = LEN_W'(DEPTH);
  localparam logic [LEN_W-1:0] QLEN_RESET = LEN_W'(32);

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] push_byte;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] pop_byte;
    logic              failed;
    logic [LEN_W-1:0]  occupancy;
    logic [LEN_W-1:0]  free_space;
    logic              is_empty;
    logic              is_full;
    logic [LEN_W-1:0]  peak_level;
  } result_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

[hdl/bfph_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bfph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/bfph_ctrl.sv]
// FIFO control: length register, positions, count, peak hold, status result.
// Depends on bfph_pkg; drives the byte store through a mem_req_t request.
module bfph_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  bfph_pkg::item_t          item,
  input  logic                     cfg_we,
  input  logic [bfph_pkg::LEN_W-1:0] cfg_data,
  output bfph_pkg::mem_req_t       req,
  output logic                     done,
  output logic                     pop_ok,
  output bfph_pkg::result_t        status
);

  logic [bfph_pkg::LEN_W-1:0]  queue_length;
  logic [bfph_pkg::ADDR_W-1:0] wr_pos, wr_pos_next;
  logic [bfph_pkg::ADDR_W-1:0] rd_pos, rd_pos_next;
  logic [bfph_pkg::LEN_W-1:0]  held, held_next;
  logic [bfph_pkg::LEN_W-1:0]  peak, peak_next;
  logic [bfph_pkg::LEN_W-1:0]  len;
  logic [bfph_pkg::LEN_W-1:0]  wr_inc, rd_inc;
  logic                        push_ok, pull_ok, fail;

  assign len = (queue_length > bfph_pkg::DEPTH_LEN) ? bfph_pkg::DEPTH_LEN : queue_length;

  assign wr_inc = bfph_pkg::LEN_W'(wr_pos) + 1'b1;
  assign rd_inc = bfph_pkg::LEN_W'(rd_pos) + 1'b1;

  always_comb begin
    wr_pos_next = wr_pos;
    rd_pos_next = rd_pos;
    held_next   = held;
    push_ok     = 1'b0;
    pull_ok     = 1'b0;
    fail        = 1'b0;
    unique case (item.cmd)
      bfph_pkg::CMD_PUSH: begin
        if (held < len) begin
          push_ok     = 1'b1;
          wr_pos_next = (wr_inc >= len) ? '0 : wr_inc[bfph_pkg::ADDR_W-1:0];
          held_next   = held + 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
      bfph_pkg::CMD_POP: begin
        if (held != '0) begin
          pull_ok     = 1'b1;
          rd_pos_next = (rd_inc >= len) ? '0 : rd_inc[bfph_pkg::ADDR_W-1:0];
          held_next   = held - 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
      bfph_pkg::CMD_CLEAR: begin
        wr_pos_next = '0;
        rd_pos_next = '0;
        held_next   = '0;
      end
      default: begin
        // unused command: hold everything
      end
    endcase
    peak_next = (held_next > peak) ? held_next : peak;
  end

  always_comb begin
    req.wr_en   = accept && push_ok;
    req.wr_addr = wr_pos;
    req.wr_data = item.push_byte;
    req.rd_en   = accept && pull_ok;
    req.rd_addr = rd_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_length <= bfph_pkg::QLEN_RESET;
      wr_pos       <= '0;
      rd_pos       <= '0;
      held         <= '0;
      peak         <= '0;
      done         <= 1'b0;
    end else begin
      if (cfg_we) begin
        queue_length <= cfg_data;
      end
      if (accept) begin
        wr_pos <= wr_pos_next;
        rd_pos <= rd_pos_next;
        held   <= held_next;
        peak   <= peak_next;
      end
      done <= accept;
    end
  end

  // Result status register; pop_byte is filled in from the store downstream.
  always_ff @(posedge clk) begin
    if (accept) begin
      pop_ok            <= pull_ok;
      status.pop_byte   <= '0;
      status.failed     <= fail;
      status.occupancy  <= held_next;
      status.free_space <= (held_next < len) ? (len - held_next) : '0;
      status.is_empty   <= (held_next == '0);
      status.is_full    <= (held_next >= len);
      status.peak_level <= peak_next;
    end
  end

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    accept && item.cmd == bfph_pkg::CMD_PUSH && !fail |=> held == $past(held) + 1'b1)
    else $error("successful push did not raise the count");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    accept && item.cmd == bfph_pkg::CMD_CLEAR |=> held == '0 && wr_pos == '0 && rd_pos == '0)
    else $error("clear left positions or count nonzero");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    done |-> status.occupancy == held && status.peak_level == peak)
    else $error("reported status differs from held state");

  a_peak_covers: assert property (@(posedge clk) disable iff (rst)
    peak >= held)
    else $error("peak below current count");

  a_one_port: assert property (@(posedge clk) disable iff (rst)
    !(req.wr_en && req.rd_en))
    else $error("store written and read for one beat");

endmodule

[hdl/byte_ring_fifo_peak_hold_core.sv]
// Top level of the byte ring FIFO with peak hold.
// Depends on bfph_pkg, bfph_ctrl and bfph_ram.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------
//  command  | start, busy                | item   (bfph_pkg::item_t)
//  result   | done                       | result (bfph_pkg::result_t)
//  config   | cfg_valid, cfg_ready       | cfg_data (queue length)
//
// One command per cycle; busy stays low. The result beat comes in the cycle
// after its command, as the status and the byte store read are both registered.
// Synchronous reset clears positions, count, peak and sets the length to 32;
// the byte store is not cleared. The receiver cannot stall the result.
module byte_ring_fifo_peak_hold_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  bfph_pkg::item_t            item,
  output logic                       done,
  output bfph_pkg::result_t          result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bfph_pkg::LEN_W-1:0] cfg_data
);

  bfph_pkg::mem_req_t          req;
  bfph_pkg::result_t           status;
  logic                        pop_ok;
  logic [bfph_pkg::DATA_W-1:0] rd_data;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  bfph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (start && !busy),
    .item     (item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .req      (req),
    .done     (done),
    .pop_ok   (pop_ok),
    .status   (status)
  );

  bfph_ram #(
    .WIDTH (bfph_pkg::DATA_W),
    .DEPTH (bfph_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (req.wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr),
    .rd_data (rd_data)
  );

  // Drop the stored byte unless this beat is a successful pop.
  always_comb begin
    result          = status;
    result.pop_byte = pop_ok ? rd_data : '0;
  end

endmodule

[tb/tb_byte_ring_fifo_peak_hold_core.sv]
// Self-checking testbench for byte_ring_fifo_peak_hold_core: push, pop, clear and
// length changes against an in-bench FIFO predictor, with random sender gaps.
// Depends on bfph_pkg and the RTL under hdl/.
`timescale 1ns / 100ps

module tb_byte_ring_fifo_peak_hold_core;

  localparam logic [bfph_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  bfph_pkg::item_t            item;
  logic                       done;
  bfph_pkg::result_t          result;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [bfph_pkg::LEN_W-1:0] cfg_data;

  // Predictor state
  logic [bfph_pkg::DATA_W-1:0] fifo_bytes [bfph_pkg::DEPTH];
  logic [bfph_pkg::ADDR_W-1:0] wr_pos;
  logic [bfph_pkg::ADDR_W-1:0] rd_pos;
  logic [bfph_pkg::LEN_W-1:0]  fill_level;
  logic [bfph_pkg::LEN_W-1:0]  peak_fill;
  logic [bfph_pkg::LEN_W-1:0]  length_reg;
  bfph_pkg::result_t           expected_status_q [$];

  int mismatches    = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;

  byte_ring_fifo_peak_hold_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[byte_ring_fifo_peak_hold_core] ERROR");
      $finish;
    end
  end

  function automatic logic [bfph_pkg::ADDR_W-1:0] step_pos(logic [bfph_pkg::ADDR_W-1:0] pos,
                                                           int len);
    if (int'(pos) + 1 >= len) return '0;
    return pos + 1'b1;
  endfunction

  // Apply one command to the predicted queue and return the status after it.
  function automatic bfph_pkg::result_t predict_status(bfph_pkg::item_t it);
    bfph_pkg::result_t r;
    int                len;
    len = (length_reg > bfph_pkg::DEPTH_LEN) ? bfph_pkg::DEPTH : int'(length_reg);
    r = '0;
    case (it.cmd)
      bfph_pkg::CMD_PUSH: begin
        if (int'(fill_level) < len) begin
          fifo_bytes[wr_pos] = it.push_byte;
          wr_pos = step_pos(wr_pos, len);
          fill_level = fill_level + 1'b1;
          if (fill_level > peak_fill) peak_fill = fill_level;
        end else begin
          r.failed = 1'b1;
        end
      end
      bfph_pkg::CMD_POP: begin
        if (fill_level != 0) begin
          r.pop_byte = fifo_bytes[rd_pos];
          rd_pos = step_pos(rd_pos, len);
          fill_level = fill_level - 1'b1;
        end else begin
          r.failed = 1'b1;
        end
      end
      bfph_pkg::CMD_CLEAR: begin
        wr_pos = '0;
        rd_pos = '0;
        fill_level = '0;
      end
      default: ;
    endcase
    r.occupancy  = fill_level;
    r.free_space = (int'(fill_level) < len) ?
                   bfph_pkg::LEN_W'(len - int'(fill_level)) : '0;
    r.is_empty   = (fill_level == 0);
    r.is_full    = (int'(fill_level) >= len);
    r.peak_level = peak_fill;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Track accepted beats, then compare each result beat with the oldest prediction.
  always @(posedge clk) begin : status_monitor
    bfph_pkg::result_t want;
    if (rst) begin
      foreach (fifo_bytes[i]) fifo_bytes[i] = '0;
      wr_pos = '0;
      rd_pos = '0;
      fill_level = '0;
      peak_fill = '0;
      length_reg = bfph_pkg::QLEN_RESET;
      expected_status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) length_reg = cfg_data;
      if (start && !busy) expected_status_q.push_back(predict_status(item));
      if (done) begin
        if (expected_status_q.size() == 0) begin
          report_mismatch("result beat with no command pending");
        end else begin
          want = expected_status_q.pop_front();
          check_field("pop_byte", result.pop_byte, want.pop_byte);
          check_field("failed", result.failed, want.failed);
          check_field("occupancy", result.occupancy, want.occupancy);
          check_field("free_space", result.free_space, want.free_space);
          check_field("is_empty", result.is_empty, want.is_empty);
          check_field("is_full", result.is_full, want.is_full);
          check_field("peak_level", result.peak_level, want.peak_level);
        end
      end
    end
  end

  // Send one command beat after a random run of idle cycles; start stays high.
  task automatic send_item(logic [bfph_pkg::CMD_W-1:0] cmd, logic [bfph_pkg::DATA_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    item  <= '{cmd: cmd, push_byte: b};
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every predicted beat has come back.
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(logic [bfph_pkg::LEN_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write every entry once at low occupancy so no later pop reads an unwritten entry.
  task automatic test_prime_store();
    logic [bfph_pkg::DATA_W-1:0] b;
    send_idle_pct = 0;
    for (int i = 0; i < bfph_pkg::DEPTH; i++) begin
      b = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
      send_item(bfph_pkg::CMD_PUSH, b);
      send_item(bfph_pkg::CMD_POP, 8'($urandom));
    end
  endtask

  task automatic test_special_cases();
    send_idle_pct = 0;
    send_item(bfph_pkg::CMD_POP, 8'h00);       // empty pop fails
    send_item(CMD_UNUSED, 8'hFF);              // unused command changes nothing
    send_item(bfph_pkg::CMD_PUSH, 8'hFF);
    send_item(bfph_pkg::CMD_PUSH, 8'h00);
    send_item(bfph_pkg::CMD_CLEAR, 8'h5A);     // clear keeps the peak
    send_item(bfph_pkg::CMD_POP, 8'h00);
    set_length(6'd0);                          // zero length: every push fails
    send_item(bfph_pkg::CMD_PUSH, 8'h81);
    send_item(bfph_pkg::CMD_POP, 8'h00);
    set_length(6'd1);
    send_item(bfph_pkg::CMD_PUSH, 8'hA5);
    send_item(bfph_pkg::CMD_PUSH, 8'h3C);
    send_item(bfph_pkg::CMD_POP, 8'h00);
    set_length(6'd63);                         // above depth acts as full depth
    send_item(bfph_pkg::CMD_PUSH, 8'h11);
    send_item(bfph_pkg::CMD_PUSH, 8'h22);
    send_item(bfph_pkg::CMD_PUSH, 8'h33);
    set_length(6'd2);                          // shrink below occupancy, then drain
    send_item(bfph_pkg::CMD_PUSH, 8'h44);
    send_item(bfph_pkg::CMD_POP, 8'h00);
    send_item(bfph_pkg::CMD_POP, 8'h00);
    send_item(bfph_pkg::CMD_POP, 8'h00);
    send_item(bfph_pkg::CMD_POP, 8'h00);
    set_length(bfph_pkg::LEN_W'(bfph_pkg::DEPTH));
    send_item(bfph_pkg::CMD_CLEAR, 8'h00);
  endtask

  task automatic test_random_traffic(int idle_pct, int segments, int per_segment);
    int                          push_pct;
    int                          r;
    logic [bfph_pkg::LEN_W-1:0]  len;
    logic [bfph_pkg::CMD_W-1:0]  cmd;
    send_idle_pct = idle_pct;
    for (int s = 0; s < segments; s++) begin
      case ($urandom_range(0, 9))
        0:       len = 6'd0;
        1:       len = 6'd1;
        2:       len = bfph_pkg::LEN_W'(bfph_pkg::DEPTH);
        3:       len = 6'd63;
        default: len = bfph_pkg::LEN_W'($urandom_range(2, 40));
      endcase
      set_length(len);
      for (int i = 0; i < per_segment; i++) begin
        // re-pick the bias now and then so the level swings between empty and full
        if (i % 25 == 0) push_pct = $urandom_range(15, 85);
        r = $urandom_range(0, 99);
        if (r < 2)                                 cmd = bfph_pkg::CMD_CLEAR;
        else if (r < 4)                            cmd = CMD_UNUSED;
        else if ($urandom_range(0, 99) < push_pct) cmd = bfph_pkg::CMD_PUSH;
        else                                       cmd = bfph_pkg::CMD_POP;
        send_item(cmd, 8'($urandom));
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_prime_store();
    test_special_cases();
    test_random_traffic(6, 8, 75);
    test_random_traffic(46, 8, 75);
    test_random_traffic(0, 8, 75);
    wait_idle();

    if (mismatches == 0)
      $display("[byte_ring_fifo_peak_hold_core] OK");
    else
      $display("[byte_ring_fifo_peak_hold_core] ERROR");
    $finish;
  end

endmodule

[byte_ring_fifo_peak_hold_core.f]
hdl/bfph_pkg.sv
hdl/bfph_ram.sv
hdl/bfph_ctrl.sv
hdl/byte_ring_fifo_peak_hold_core.sv
tb/tb_byte_ring_fifo_peak_hold_core.sv
